// ===== src/plm_pkg.sv =====
package plm_pkg;

  // Default geometry of the engine.
  localparam int MAX_HAPS_DEF  = 64;
  localparam int LEN_WIDTH_DEF = 16;

  // Fixed field widths of the ports.
  localparam int MODE_W   = 3;
  localparam int HAP_W    = 6;
  localparam int HCNT_W   = 7;
  localparam int MINLEN_W = 16;
  localparam int SITE_W   = 16;
  localparam int OLEN_W   = 16;
  localparam int CFG_W    = 16;

  // Reset values of the configuration registers.
  localparam logic [HCNT_W-1:0]   HAP_COUNT_RST = 7'd64;
  localparam logic [MINLEN_W-1:0] MIN_LEN_RST   = 16'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD        = 3'd0,
    MODE_REPORT_DIFF = 3'd1,
    MODE_ADVANCE     = 3'd2,
    MODE_REPORT_TAIL = 3'd3,
    MODE_RESTART     = 3'd4
  } plm_mode_t;

  // Configuration register indexes.
  localparam logic CFG_HAP_COUNT = 1'b0;
  localparam logic CFG_MIN_LEN   = 1'b1;

  // Write enables from the sequencer to the state memories.
  typedef struct packed {
    logic ord_we;
    logic len_we;
    logic al_we;
  } plm_wen_t;

endpackage

// ===== src/plm_store.sv =====
module plm_store #(
  parameter int MAX_HAPS  = plm_pkg::MAX_HAPS_DEF,
  parameter int LEN_WIDTH = plm_pkg::LEN_WIDTH_DEF,
  localparam int HW = $clog2(MAX_HAPS)
) (
  input  logic                 clk,
  input  plm_pkg::plm_wen_t    wen,
  input  logic [HW:0]          ord_waddr,
  input  logic [HW-1:0]        ord_wdata,
  input  logic [HW:0]          ord_raddr,
  output logic [HW-1:0]        ord_rdata,
  input  logic [HW-1:0]        len_waddr,
  input  logic [LEN_WIDTH-1:0] len_wdata,
  input  logic [HW-1:0]        hap_raddr,
  output logic [LEN_WIDTH-1:0] len_rdata,
  input  logic [HW-1:0]        al_waddr,
  input  logic                 al_wdata,
  output logic                 al_rdata
);

  // Sort order in two banks: one is current, the other receives the next order.
  logic [HW-1:0]        ord_mem [2**(HW+1)];
  logic [LEN_WIDTH-1:0] len_mem [MAX_HAPS];
  logic                 al_mem  [MAX_HAPS];

  always_ff @(posedge clk) begin
    if (wen.ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rdata <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (wen.len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_rdata <= len_mem[hap_raddr];
  end

  always_ff @(posedge clk) begin
    if (wen.al_we) begin
      al_mem[al_waddr] <= al_wdata;
    end
    al_rdata <= al_mem[hap_raddr];
  end

endmodule

// ===== src/pbwt_long_match_engine.sv =====
// Channel  | Ports                                             | Beat taken when
// ---------+---------------------------------------------------+------------------------
// input    | start, busy, in_mode, in_hap_index, in_allele,    | start high, busy low
//          | in_sorted_position                                |
// result   | out_valid, out_site_number, out_hap_low,          | out_valid high (1 cycle)
//          | out_hap_high, out_match_length, out_last          |
// config   | cfg_we, cfg_index, cfg_data                       | cfg_we high
//
// A load or an unused mode does not make the engine busy. An advance makes two walks:
// one walk through the order counts the allele-0 haplotypes, a second walk splits the
// order into the other bank and updates the lengths in place. Each walk moves one entry
// per cycle through the chained reads of the order memory and then the length and allele
// memories.
// A report walks the order onward from the sorted position and gives at most one result
// beat per cycle; the receiver cannot stall, so results are simply presented.
// After reset and after a restart item a clearing pass writes the identity order and
// zero lengths; busy is high during it.
module pbwt_long_match_engine #(
  parameter int MAX_HAPS  = plm_pkg::MAX_HAPS_DEF,
  parameter int LEN_WIDTH = plm_pkg::LEN_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [plm_pkg::MODE_W-1:0]    in_mode,
  input  logic [plm_pkg::HAP_W-1:0]     in_hap_index,
  input  logic                          in_allele,
  input  logic [plm_pkg::HAP_W-1:0]     in_sorted_position,
  output logic                          out_valid,
  output logic [plm_pkg::SITE_W-1:0]    out_site_number,
  output logic [plm_pkg::HAP_W-1:0]     out_hap_low,
  output logic [plm_pkg::HAP_W-1:0]     out_hap_high,
  output logic [plm_pkg::OLEN_W-1:0]    out_match_length,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [plm_pkg::CFG_W-1:0]     cfg_data
);
  import plm_pkg::*;

  localparam int HW   = $clog2(MAX_HAPS);
  localparam int CW   = HW + 1;
  localparam int LW   = LEN_WIDTH;
  localparam int CMPW = (LW > MINLEN_W) ? LW : MINLEN_W;
  localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_COUNT,
    ST_SPLIT,
    ST_REPORT
  } state_t;

  state_t state_r;

  logic [HCNT_W-1:0]   hap_count_r;
  logic [MINLEN_W-1:0] min_len_r;
  logic [SITE_W-1:0]   site_r;
  logic [CW-1:0]       zc_r;
  logic                bank_r;

  // Walker and its two read stages.
  logic [CW-1:0] k_r, kend_r, k1_r, k2_r;
  logic          v1_r, v2_r;
  logic [HW-1:0] h2_r;

  // Advance bookkeeping.
  logic [CW-1:0] cnt_r, z_r, o_r;
  logic          have0_r, have1_r, inf0_r, inf1_r;
  logic [LW-1:0] run0_r, run1_r;

  // Report bookkeeping.
  logic [CW-1:0] pos_r;
  logic          tail_r;
  logic [HW-1:0] a_r;
  logic          a_al_r;
  logic          rinf_r;
  logic [LW-1:0] rrun_r;
  logic          pend_vld_r;
  logic [HW-1:0] pend_lo_r, pend_hi_r;
  logic [OLEN_W-1:0] pend_len_r;

  logic                out_valid_r, out_last_r;
  logic [SITE_W-1:0]   out_site_r;
  logic [HW-1:0]       out_lo_r, out_hi_r;
  logic [OLEN_W-1:0]   out_len_r;

  // Memory interface.
  plm_wen_t      wen;
  logic [HW:0]   ord_waddr, ord_raddr;
  logic [HW-1:0] ord_wdata, ord_rdata;
  logic [HW-1:0] len_waddr;
  logic [LW-1:0] len_wdata, len_rdata;
  logic          al_rdata;

  logic [CW-1:0] n_w;
  logic          walking, issue, done;
  logic          in_split;
  logic [LW-1:0] nl_w;
  logic          len_lt_min;
  logic [LW-1:0] run_new;
  logic [HW-1:0] lo_w, hi_w;
  logic          pos_ok;

  function automatic logic [LW-1:0] nxt_len(input logic [LW-1:0] own, input logic have,
                                             input logic inf, input logic [LW-1:0] run);
    logic [LW-1:0] m;
    begin
      m = (inf || own < run) ? own : run;
      if (!have) begin
        nxt_len = '0;
      end else if (m == LEN_MAX) begin
        nxt_len = LEN_MAX;
      end else begin
        nxt_len = m + 1'b1;
      end
    end
  endfunction

  // Haplotypes in use, clamped to the store size.
  assign n_w = (hap_count_r > HCNT_W'(MAX_HAPS)) ? CW'(MAX_HAPS) : CW'(hap_count_r);

  assign walking = (state_r == ST_COUNT) || (state_r == ST_SPLIT) || (state_r == ST_REPORT);
  assign issue   = walking && (k_r < kend_r);
  assign done    = !issue && !v1_r && !v2_r;
  assign in_split = (state_r == ST_SPLIT) && v2_r && (k2_r < n_w);

  // New length of the entry in stage two, taken against the opposite group's run.
  assign nl_w = al_rdata ? nxt_len(len_rdata, have0_r, inf0_r, run0_r)
                         : nxt_len(len_rdata, have1_r, inf1_r, run1_r);

  assign len_lt_min = CMPW'(len_rdata) < CMPW'(min_len_r);
  assign run_new    = (rinf_r || len_rdata < rrun_r) ? len_rdata : rrun_r;
  assign lo_w       = (a_r < h2_r) ? a_r : h2_r;
  assign hi_w       = (a_r < h2_r) ? h2_r : a_r;
  assign pos_ok     = (n_w >= CW'(2)) && ({1'b0, in_sorted_position} < HCNT_W'(n_w));

  always_comb begin
    wen.al_we  = (state_r == ST_IDLE) && start && (in_mode == MODE_LOAD)
                 && ({1'b0, in_hap_index} < HCNT_W'(MAX_HAPS));
    wen.ord_we = (state_r == ST_CLEAR) || ((state_r == ST_SPLIT) && v2_r);
    wen.len_we = (state_r == ST_CLEAR) || in_split;

    ord_raddr = {bank_r, k_r[HW-1:0]};
    if (state_r == ST_CLEAR) begin
      ord_waddr = {1'b0, k_r[HW-1:0]};
      ord_wdata = k_r[HW-1:0];
      len_waddr = k_r[HW-1:0];
      len_wdata = '0;
    end else begin
      // Entries past the panel keep their place in the new bank.
      if (k2_r < n_w) begin
        ord_waddr = {~bank_r, al_rdata ? o_r[HW-1:0] : z_r[HW-1:0]};
      end else begin
        ord_waddr = {~bank_r, k2_r[HW-1:0]};
      end
      ord_wdata = h2_r;
      len_waddr = h2_r;
      len_wdata = nl_w;
    end
  end

  plm_store #(
    .MAX_HAPS (MAX_HAPS),
    .LEN_WIDTH(LEN_WIDTH)
  ) u_store (
    .clk      (clk),
    .wen      (wen),
    .ord_waddr(ord_waddr),
    .ord_wdata(ord_wdata),
    .ord_raddr(ord_raddr),
    .ord_rdata(ord_rdata),
    .len_waddr(len_waddr),
    .len_wdata(len_wdata),
    .hap_raddr(ord_rdata),
    .len_rdata(len_rdata),
    .al_waddr (in_hap_index[HW-1:0]),
    .al_wdata (in_allele),
    .al_rdata (al_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      k_r         <= '0;
      kend_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      bank_r      <= 1'b0;
      site_r      <= '0;
      zc_r        <= '0;
      hap_count_r <= HAP_COUNT_RST;
      min_len_r   <= MIN_LEN_RST;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        if (cfg_index == CFG_HAP_COUNT) begin
          hap_count_r <= cfg_data[HCNT_W-1:0];
        end else begin
          min_len_r <= cfg_data[MINLEN_W-1:0];
        end
      end

      // Read pipeline: order entry, then length and allele of that haplotype.
      v1_r <= issue;
      k1_r <= k_r;
      if (issue) begin
        k_r <= k_r + 1'b1;
      end
      v2_r <= v1_r;
      k2_r <= k1_r;
      h2_r <= ord_rdata;

      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            unique case (in_mode)
              MODE_REPORT_DIFF, MODE_REPORT_TAIL: begin
                if (pos_ok) begin
                  state_r    <= ST_REPORT;
                  k_r        <= CW'(in_sorted_position);
                  pos_r      <= CW'(in_sorted_position);
                  kend_r     <= n_w;
                  tail_r     <= (in_mode == MODE_REPORT_TAIL);
                  rinf_r     <= 1'b1;
                  pend_vld_r <= 1'b0;
                end
              end
              MODE_ADVANCE: begin
                state_r <= ST_COUNT;
                k_r     <= '0;
                kend_r  <= n_w;
                cnt_r   <= '0;
              end
              MODE_RESTART: begin
                state_r <= ST_CLEAR;
                k_r     <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        ST_CLEAR: begin
          k_r <= k_r + 1'b1;
          if (k_r == CW'(MAX_HAPS - 1)) begin
            state_r <= ST_IDLE;
            bank_r  <= 1'b0;
            site_r  <= '0;
            zc_r    <= '0;
          end
        end

        ST_COUNT: begin
          if (v2_r && !al_rdata) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (done) begin
            zc_r    <= cnt_r;
            state_r <= ST_SPLIT;
            k_r     <= '0;
            kend_r  <= CW'(MAX_HAPS);
            z_r     <= '0;
            o_r     <= cnt_r;
            have0_r <= 1'b0;
            have1_r <= 1'b0;
          end
        end

        ST_SPLIT: begin
          if (in_split) begin
            if (!al_rdata) begin
              z_r     <= z_r + 1'b1;
              have1_r <= 1'b1;
              inf1_r  <= 1'b1;
              if (have0_r && (inf0_r || len_rdata < run0_r)) begin
                run0_r <= len_rdata;
                inf0_r <= 1'b0;
              end
            end else begin
              o_r     <= o_r + 1'b1;
              have0_r <= 1'b1;
              inf0_r  <= 1'b1;
              if (have1_r && (inf1_r || len_rdata < run1_r)) begin
                run1_r <= len_rdata;
                inf1_r <= 1'b0;
              end
            end
          end
          if (done) begin
            bank_r  <= ~bank_r;
            site_r  <= site_r + 1'b1;
            state_r <= ST_IDLE;
          end
        end

        ST_REPORT: begin
          if (v2_r) begin
            if (k2_r == pos_r) begin
              a_r    <= h2_r;
              a_al_r <= al_rdata;
            end else if (len_lt_min) begin
              // The run broke: close the item with whatever is pending.
              state_r <= ST_IDLE;
              v1_r    <= 1'b0;
              v2_r    <= 1'b0;
              if (pend_vld_r) begin
                out_valid_r <= 1'b1;
                out_site_r  <= site_r;
                out_lo_r    <= pend_lo_r;
                out_hi_r    <= pend_hi_r;
                out_len_r   <= pend_len_r;
                out_last_r  <= 1'b1;
                pend_vld_r  <= 1'b0;
              end
            end else begin
              rrun_r <= run_new;
              rinf_r <= 1'b0;
              if (tail_r || (a_al_r != al_rdata)) begin
                // Hold each match back one step so the final one can carry last.
                if (pend_vld_r) begin
                  out_valid_r <= 1'b1;
                  out_site_r  <= site_r;
                  out_lo_r    <= pend_lo_r;
                  out_hi_r    <= pend_hi_r;
                  out_len_r   <= pend_len_r;
                  out_last_r  <= 1'b0;
                end
                pend_vld_r <= 1'b1;
                pend_lo_r  <= lo_w;
                pend_hi_r  <= hi_w;
                pend_len_r <= OLEN_W'(run_new);
              end
            end
          end else if (done) begin
            state_r <= ST_IDLE;
            if (pend_vld_r) begin
              out_valid_r <= 1'b1;
              out_site_r  <= site_r;
              out_lo_r    <= pend_lo_r;
              out_hi_r    <= pend_hi_r;
              out_len_r   <= pend_len_r;
              out_last_r  <= 1'b1;
              pend_vld_r  <= 1'b0;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_site_number  = out_site_r;
  assign out_hap_low      = HAP_W'(out_lo_r);
  assign out_hap_high     = HAP_W'(out_hi_r);
  assign out_match_length = out_len_r;
  assign out_last         = out_last_r;

  // zc_r keeps the allele-0 count of the last advance as part of the block state.
  logic zc_unused_w;
  assign zc_unused_w = ^zc_r;

endmodule

// ===== src/plm_checker.sv =====
module plm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [plm_pkg::MODE_W-1:0] in_mode,
  input logic                       out_valid
);
  import plm_pkg::*;

  // Results only follow cycles in which the engine was working.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without preceding busy cycle");

  // An accepted item never meets a result beat in the following cycle.
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result beat right after an accepted item");

  // Reset starts the clearing pass.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("engine not busy after reset");

  // An advance always occupies the engine.
  a_advance_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_ADVANCE)) |=> busy)
    else $error("advance accepted without going busy");

endmodule

bind pbwt_long_match_engine plm_checker u_plm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_mode  (in_mode),
  .out_valid(out_valid)
);
